// File: rtl/ura_pkg.sv
package ura_pkg;

    typedef enum logic [2:0] {
        REQ_TICK = 3'd0,
        REQ_ECHO = 3'd1,
        REQ_SET  = 3'd2,
        REQ_UP   = 3'd3,
        REQ_DOWN = 3'd4
    } req_type_t;

    typedef enum logic {
        CFG_RANGE_LIMIT    = 1'b0,
        CFG_TRIGGER_PERIOD = 1'b1
    } cfg_index_t;

    localparam logic [7:0] SEG_DASH  = 8'hBF;
    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] DP_MASK   = 8'h7F;
    localparam logic [3:0] SEL_NONE  = 4'hF;
    localparam logic [3:0] DIGIT_DASH = 4'd10;

    localparam logic [7:0] SEG_CODE [11] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98, 8'hBF
    };
    localparam logic [3:0] SEL_CODE [4] = '{4'hE, 4'hD, 4'hB, 4'h7};

    // 17 * ceil(2^31 / 1000): floor(count * 17 / 1000) = (count * ECHO_SCALE) >> 31
    localparam logic [25:0] ECHO_SCALE = 26'd36507228;
    localparam int          ECHO_SHIFT = 31;

    typedef struct packed {
        logic        setting;
        logic [1:0]  pos;
        logic [10:0] distance;
        logic        dash;
        logic [3:0]  tenths;
        logic [1:0]  units;
    } disp_state_t;

    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [7:0] seg;
        seg = SEG_DASH;
        if (d <= DIGIT_DASH)
        begin
            seg = SEG_CODE[d];
        end
        return seg;
    endfunction

endpackage

// File: rtl/ura_if.sv
interface ura_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] echo_count;
    logic        timer_overflow;

    modport source (output valid, output req_type, output echo_count,
                    output timer_overflow, input ready);
    modport sink   (input valid, input req_type, input echo_count,
                    input timer_overflow, output ready);
endinterface

interface ura_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  segment_pattern;
    logic [3:0]  digit_enable_n;
    logic        alarm_on;
    logic [10:0] distance_cm;
    logic [8:0]  threshold_cm;
    logic        set_mode;
    logic        trigger_pulse;

    modport source (output valid, output segment_pattern, output digit_enable_n,
                    output alarm_on, output distance_cm, output threshold_cm,
                    output set_mode, output trigger_pulse, input ready);
    modport sink   (input valid, input segment_pattern, input digit_enable_n,
                    input alarm_on, input distance_cm, input threshold_cm,
                    input set_mode, input trigger_pulse, output ready);
endinterface

// File: rtl/ura_display.sv
module ura_display (
    input  ura_pkg::disp_state_t st,
    output logic [7:0]           seg,
    output logic [3:0]           sel
);
    import ura_pkg::*;

    logic [9:0] rem_k;
    logic [9:0] rem_h;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [3:0] dig0;
    logic [3:0] dig1;
    logic [3:0] dig2;

    // distance below 2000, so one subtract gives distance mod 1000
    always_comb
    begin
        if (st.distance >= 11'd1000)
        begin
            rem_k = 10'(st.distance - 11'd1000);
        end
        else
        begin
            rem_k = st.distance[9:0];
        end
    end

    // parallel compares against multiples of 100, then of 10
    always_comb
    begin
        hundreds = 4'd0;
        rem_h    = rem_k;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_k >= 10'(k * 100))
            begin
                hundreds = 4'(k);
                rem_h    = rem_k - 10'(k * 100);
            end
        end
        tens = 4'd0;
        ones = rem_h[3:0];
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_h >= 10'(k * 10))
            begin
                tens = 4'(k);
                ones = 4'(rem_h - 10'(k * 10));
            end
        end
    end

    always_comb
    begin
        if (st.dash)
        begin
            dig0 = DIGIT_DASH;
            dig1 = DIGIT_DASH;
            dig2 = DIGIT_DASH;
        end
        else
        begin
            dig0 = ones;
            dig1 = tens;
            dig2 = hundreds;
        end
    end

    always_comb
    begin
        sel = SEL_CODE[st.pos];
        seg = SEG_BLANK;
        if (!st.setting)
        begin
            unique case (st.pos)
                2'd0: seg = digit_seg(dig0);
                2'd1: seg = digit_seg(dig1);
                2'd2: seg = digit_seg(dig2) & DP_MASK;
                2'd3: seg = SEG_BLANK;
            endcase
        end
        else
        begin
            unique case (st.pos)
                2'd1: seg = digit_seg(st.tenths);
                2'd2: seg = digit_seg({2'b00, st.units}) & DP_MASK;
                2'd0, 2'd3: seg = SEG_DASH;
            endcase
        end
    end

endmodule

// File: rtl/ultrasonic_range_alarm_controller.sv
// Ultrasonic rangefinder controller with a distance alarm and a four-digit
// multiplexed seven-segment display.
// Channel req carries one event per transaction: scan tick, echo done (with
// the echo count in 1 us units and the timer overflow flag), set, up or down.
// Channel res returns exactly one result per event: segment pattern, digit
// select, alarm, distance, threshold, set mode and trigger pulse; segment and
// select come from the state before the event, the rest from the state after.
// One event is taken every cycle unless res stalls. The echo path is a single
// 16x26 constant multiply into the stored distance; the display digits are
// decoded from the stored distance when a tick drives the display, so each
// path sits between two registers. The result sits in an output register; a
// new event is accepted whenever that register is empty or being drained, so
// a stalled receiver holds the result and backs up the request side only
// while it stalls. Configuration (cfg_we, cfg_index, cfg_data) writes
// range_limit_cm at index 0 and trigger_period_ticks at index 1; the user
// must write it only while idle, which the block does not enforce. Reset
// clears distance, display digits and set mode, sets the threshold to 1.0 m,
// the range limit to 300 cm and the trigger period to 400 ticks.
module ultrasonic_range_alarm_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [9:0]        cfg_data,
    ura_req_if.sink           req,
    ura_res_if.source         res
);
    import ura_pkg::*;

    logic [9:0]  range_limit_reg;
    logic [8:0]  period_reg;

    logic [10:0] distance_reg, distance_next;
    logic        dash_reg, dash_next;
    logic        setting_reg, setting_next;
    logic [3:0]  tenths_reg, tenths_next;
    logic [1:0]  units_reg, units_next;
    logic [1:0]  pos_reg, pos_next;
    logic [8:0]  tick_reg, tick_next;

    logic        res_valid_reg, res_valid_next;
    logic [7:0]  res_seg_reg, res_seg_next;
    logic [3:0]  res_sel_reg, res_sel_next;
    logic        res_alarm_reg, res_alarm_next;
    logic [10:0] res_dist_reg;
    logic [8:0]  res_thr_reg, res_thr_next;
    logic        res_set_reg;
    logic        res_trig_reg, res_trig_next;

    logic        accept;
    logic [41:0] echo_prod;
    logic [10:0] echo_dist;
    logic [9:0]  tick_inc;
    logic [7:0]  disp_seg;
    logic [3:0]  disp_sel;
    disp_state_t disp_st;

    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    assign echo_prod = 42'(req.echo_count) * 42'(ECHO_SCALE);
    assign echo_dist = echo_prod[ECHO_SHIFT+10:ECHO_SHIFT];
    assign tick_inc  = 10'(tick_reg) + 10'd1;

    assign disp_st = '{setting:  setting_reg,
                       pos:      pos_reg,
                       distance: distance_reg,
                       dash:     dash_reg,
                       tenths:   tenths_reg,
                       units:    units_reg};

    ura_display u_display (
        .st  (disp_st),
        .seg (disp_seg),
        .sel (disp_sel)
    );

    always_comb
    begin
        distance_next = distance_reg;
        dash_next     = dash_reg;
        setting_next  = setting_reg;
        tenths_next   = tenths_reg;
        units_next    = units_reg;
        pos_next      = pos_reg;
        tick_next     = tick_reg;
        res_seg_next  = SEG_BLANK;
        res_sel_next  = SEL_NONE;
        res_trig_next = 1'b0;

        unique case (req_type_t'(req.req_type))
            REQ_TICK:
            begin
                res_seg_next = disp_seg;
                res_sel_next = disp_sel;
                pos_next     = pos_reg + 2'd1;
                if (tick_inc >= 10'(period_reg))
                begin
                    tick_next     = 9'd0;
                    res_trig_next = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc[8:0];
                end
            end
            REQ_ECHO:
            begin
                distance_next = echo_dist;
                dash_next     = (echo_dist >= 11'(range_limit_reg)) || req.timer_overflow;
            end
            REQ_SET:
            begin
                setting_next = !setting_reg;
            end
            REQ_UP:
            begin
                if (setting_reg)
                begin
                    if (tenths_reg >= 4'd9)
                    begin
                        tenths_next = 4'd0;
                        units_next  = (units_reg >= 2'd2) ? 2'd0 : units_reg + 2'd1;
                    end
                    else
                    begin
                        tenths_next = tenths_reg + 4'd1;
                    end
                end
            end
            REQ_DOWN:
            begin
                if (setting_reg)
                begin
                    if (tenths_reg == 4'd0)
                    begin
                        tenths_next = 4'd9;
                        units_next  = (units_reg == 2'd0) ? 2'd2 : units_reg - 2'd1;
                    end
                    else
                    begin
                        tenths_next = tenths_reg - 4'd1;
                    end
                end
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase

        res_thr_next   = 9'(units_next) * 9'd100 + 9'(tenths_next) * 9'd10;
        res_alarm_next = distance_next < 11'(res_thr_next);

        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg <= 10'd300;
            period_reg      <= 9'd400;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RANGE_LIMIT:    range_limit_reg <= cfg_data;
                CFG_TRIGGER_PERIOD: period_reg      <= cfg_data[8:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_reg  <= 11'd0;
            dash_reg      <= 1'b0;
            setting_reg   <= 1'b0;
            tenths_reg    <= 4'd0;
            units_reg     <= 2'd1;
            pos_reg       <= 2'd0;
            tick_reg      <= 9'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                distance_reg <= distance_next;
                dash_reg     <= dash_next;
                setting_reg  <= setting_next;
                tenths_reg   <= tenths_next;
                units_reg    <= units_next;
                pos_reg      <= pos_next;
                tick_reg     <= tick_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_seg_reg   <= res_seg_next;
            res_sel_reg   <= res_sel_next;
            res_alarm_reg <= res_alarm_next;
            res_dist_reg  <= distance_next;
            res_thr_reg   <= res_thr_next;
            res_set_reg   <= setting_next;
            res_trig_reg  <= res_trig_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.segment_pattern = res_seg_reg;
    assign res.digit_enable_n  = res_sel_reg;
    assign res.alarm_on        = res_alarm_reg;
    assign res.distance_cm     = res_dist_reg;
    assign res.threshold_cm    = res_thr_reg;
    assign res.set_mode        = res_set_reg;
    assign res.trigger_pulse   = res_trig_reg;

    // threshold digits stay within 0.0 .. 2.9 m
    a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
        tenths_reg <= 4'd9 && units_reg <= 2'd2)
        else $error("threshold digits out of range");

    // a trigger only comes with a tick, which always selects a digit
    a_trig_sel: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_trig_reg |-> res_sel_reg != SEL_NONE)
        else $error("trigger without digit select");

    // scan position advances by one on every accepted tick
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_TICK |=> pos_reg == $past(pos_reg) + 2'd1)
        else $error("scan position did not advance");

    // set event toggles set mode and shows it in the result
    a_set_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_SET |=>
            setting_reg != $past(setting_reg) && res_set_reg == setting_reg)
        else $error("set mode did not toggle");

    // alarm in the result agrees with the distance and threshold beside it
    a_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_alarm_reg == (res_dist_reg < 11'(res_thr_reg)))
        else $error("alarm disagrees with distance and threshold");

endmodule
